FILE: rtl/cic_pkg.sv
// Shared types and constants for the carousel indexer controller.
// Used by cic_args and carousel_indexer_controller_core; depends on nothing.
`timescale 1ns / 1ps

package cic_pkg;

   // Default register values after reset.
   localparam logic [15:0] HOME_THRESHOLD_RESET   = 16'd700;
   localparam logic [7:0]  FAST_MOVE_PERIOD_RESET = 8'd165;
   localparam logic [7:0]  SLOW_MOVE_PERIOD_RESET = 8'd250;
   localparam logic [7:0]  HOME_FAST_PERIOD_RESET = 8'd180;
   localparam logic [7:0]  HOME_SLOW_PERIOD_RESET = 8'd250;
   localparam logic [7:0]  LAST_INDEX_RESET       = 8'd4;

   // Number of ASCII digits taken by an argument command.
   localparam int unsigned ARG_DIGITS_DEFAULT = 3;

   // Command letters and the ASCII digit base.
   localparam logic [7:0] CHAR_MOVE    = 8'h4D; // 'M'
   localparam logic [7:0] CHAR_COUNT   = 8'h54; // 'T'
   localparam logic [7:0] CHAR_HOME    = 8'h48; // 'H'
   localparam logic [7:0] CHAR_ENABLE  = 8'h45; // 'E'
   localparam logic [7:0] CHAR_DISABLE = 8'h44; // 'D'
   localparam logic [7:0] CHAR_ONE     = 8'h4F; // 'O'
   localparam logic [7:0] CHAR_ZERO    = 8'h30; // '0'

   // Event kinds on the request channel.
   typedef enum logic [1:0] {
      CMD_SERIAL = 2'd0,
      CMD_IR     = 2'd1,
      CMD_TICK   = 2'd2,
      CMD_UNUSED = 2'd3
   } cmd_type;

   // Motor modes.
   typedef enum logic [1:0] {
      MODE_DISABLED = 2'd0,
      MODE_HOLDING  = 2'd1,
      MODE_MOVING   = 2'd2,
      MODE_SPARE    = 2'd3
   } mode_type;

   // Status codes of a result word.
   typedef enum logic [3:0] {
      ST_NONE         = 4'd0,
      ST_HOMING       = 4'd1,
      ST_OUT_OF_RANGE = 4'd2,
      ST_DONE_MOVE    = 4'd3,
      ST_MOVE_STARTED = 4'd4,
      ST_ONE_STARTED  = 4'd5,
      ST_HOMED        = 4'd6,
      ST_NOT_HOME     = 4'd7,
      ST_ONE_DONE     = 4'd8,
      ST_FOUND        = 4'd9,
      ST_STEPPED      = 4'd10,
      ST_BUMP         = 4'd11,
      ST_ACK          = 4'd12
   } status_type;

   // Register indexes on the configuration port.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOME_THRESHOLD   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FAST_MOVE_PERIOD = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOW_MOVE_PERIOD = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOME_FAST_PERIOD = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOME_SLOW_PERIOD = 3'd4;
   localparam int unsigned CSR_DATA_W = 16;

   // Request word.
   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] rx_byte;
      logic       ir_level;
   } req_type;

   // Result word.
   typedef struct packed {
      logic [1:0] motor_mode;
      logic [7:0] step_period;
      logic [7:0] current_index;
      logic [7:0] target_index;
      logic [3:0] status;
   } rsp_type;

   // Controls from the command decoder to the argument collector.
   typedef struct packed {
      logic start;    // 'M' or 'T' seen
      logic letter;   // 1 for 'T', 0 for 'M'
      logic clear;    // single-letter command seen
      logic take;     // any other byte
   } arg_ctl_type;

   // Argument collector status back to the decoder.
   typedef struct packed {
      logic       run;    // this byte completes the command
      logic       letter; // pending letter, 1 for 'T'
      logic [7:0] value;  // argument value modulo 256
   } arg_sts_type;

endpackage

FILE: rtl/cic_args.sv
// Argument collector: counts received digits and folds them into a value.
// Depends on cic_pkg for the control and status structs.
`timescale 1ns / 1ps

module cic_args #(
   parameter int unsigned ARG_DIGITS = cic_pkg::ARG_DIGITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cic_pkg::arg_ctl_type ctl,
   input  logic [7:0]           rx_byte,
   output cic_pkg::arg_sts_type sts
);

   localparam int unsigned CNT_W = $clog2(ARG_DIGITS + 2);
   localparam logic [CNT_W-1:0] CNT_RUN = CNT_W'(ARG_DIGITS + 1);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             letter_ff, letter_in;
   logic [7:0]       acc_ff, acc_in;
   logic [7:0]       digit;
   logic [7:0]       scaled;

   // Digits are accumulated as they arrive; mod 256 makes this match a later fold.
   assign digit  = rx_byte - cic_pkg::CHAR_ZERO;
   assign scaled = (acc_ff << 3) + (acc_ff << 1);

   assign sts.run    = ctl.take && (count_ff == CNT_RUN);
   assign sts.letter = letter_ff;
   assign sts.value  = acc_ff;

   // Next count, letter and accumulator.
   always_comb begin
      count_in  = count_ff;
      letter_in = letter_ff;
      acc_in    = acc_ff;
      if (ctl.start) begin
         count_in  = CNT_ONE;
         letter_in = ctl.letter;
      end else if (ctl.clear) begin
         count_in = '0;
      end else if (ctl.take) begin
         if (count_ff == CNT_RUN) begin
            count_in = '0;
         end else if (count_ff != '0) begin
            count_in = count_ff + CNT_ONE;
            acc_in   = (count_ff == CNT_ONE) ? digit : scaled + digit;
         end
      end
   end

   // Control state is reset; the accumulator is always loaded before use.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         letter_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         letter_ff <= letter_in;
      end
      acc_ff <= acc_in;
   end

endmodule

FILE: rtl/carousel_indexer_controller_core.sv
// Top level of the carousel indexer controller: handshake, registers, event logic.
// Depends on cic_pkg and cic_args.
`timescale 1ns / 1ps

// Carousel indexer controller. Each request word is one event (serial byte, IR
// level change or microstep tick) and produces exactly one result word holding
// the motor mode, step period, current and target index, and a status code.
// A request is registered on acceptance and processed once the output register is
// free or being read; the result lands in the output register, which drives
// rsp_valid, and one request per cycle is sustained while results are taken.
// The only pacing is the output register: while a result is not taken, an
// empty input register still takes one more word and then intake stalls.
// Configuration writes are accepted every cycle and should be issued only while
// no event is in flight.
module carousel_indexer_controller_core #(
   parameter int unsigned ARG_DIGITS = cic_pkg::ARG_DIGITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  cic_pkg::req_type                      req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output cic_pkg::rsp_type                      rsp_payload,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [cic_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [cic_pkg::CSR_DATA_W-1:0]        csr_data
);

   // Handshake and pipeline registers.
   logic             in_valid_ff;
   cic_pkg::req_type in_word_ff;
   logic             out_valid_ff;
   cic_pkg::rsp_type out_word_ff, out_word_in;
   logic             advance;

   // Configuration registers.
   logic [15:0] home_threshold_ff;
   logic [7:0]  fast_period_ff, slow_period_ff, home_fast_ff, home_slow_ff;

   // Controller state.
   cic_pkg::mode_type mode_ff, mode_in;
   logic [7:0]  period_ff, period_in;
   logic [7:0]  pos_ff, pos_in;
   logic [7:0]  dest_ff, dest_in;
   logic [7:0]  last_ff, last_in;
   logic        one_ff, one_in;
   logic        found_ff, found_in;
   logic        homing_ff, homing_in;
   logic        pend_ff, pend_in;
   logic        edge_ff, edge_in;
   logic        counting_ff, counting_in;
   logic [15:0] steps_ff, steps_in;

   // Decode helpers.
   cic_pkg::status_type   status;
   cic_pkg::arg_ctl_type  arg_ctl;
   cic_pkg::arg_sts_type  arg_sts;
   logic                  move_req;
   logic [7:0]            move_dest;
   logic [7:0]            pos_next;
   logic [15:0]           steps_inc;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_payload = out_word_ff;
   assign csr_ready = 1'b1;

   assign pos_next  = (pos_ff == last_ff) ? 8'd0 : pos_ff + 8'd1;
   assign steps_inc = steps_ff + 16'd1;

   cic_args #(
      .ARG_DIGITS(ARG_DIGITS)
   ) u_args (
      .clock  (clock),
      .reset  (reset),
      .ctl    (arg_ctl),
      .rx_byte(in_word_ff.rx_byte),
      .sts    (arg_sts)
   );

   // Event processing for the word in the input register.
   always_comb begin
      mode_in     = mode_ff;
      period_in   = period_ff;
      pos_in      = pos_ff;
      dest_in     = dest_ff;
      last_in     = last_ff;
      one_in      = one_ff;
      found_in    = found_ff;
      homing_in   = homing_ff;
      pend_in     = pend_ff;
      edge_in     = edge_ff;
      counting_in = counting_ff;
      steps_in    = steps_ff;
      status      = cic_pkg::ST_NONE;
      arg_ctl     = '0;
      move_req    = 1'b0;
      move_dest   = dest_ff;

      unique case (cic_pkg::cmd_type'(in_word_ff.cmd))
         cic_pkg::CMD_SERIAL: begin
            unique case (in_word_ff.rx_byte)
               cic_pkg::CHAR_MOVE: begin
                  arg_ctl.start  = advance;
                  arg_ctl.letter = 1'b0;
               end
               cic_pkg::CHAR_COUNT: begin
                  arg_ctl.start  = advance;
                  arg_ctl.letter = 1'b1;
               end
               cic_pkg::CHAR_HOME: begin
                  arg_ctl.clear = advance;
                  homing_in = 1'b1;
                  pos_in    = 8'd0;
                  mode_in   = cic_pkg::MODE_MOVING;
                  period_in = home_fast_ff;
                  status    = cic_pkg::ST_HOMING;
               end
               cic_pkg::CHAR_ENABLE: begin
                  arg_ctl.clear = advance;
                  mode_in = cic_pkg::MODE_HOLDING;
                  status  = cic_pkg::ST_ACK;
               end
               cic_pkg::CHAR_DISABLE: begin
                  arg_ctl.clear = advance;
                  mode_in = cic_pkg::MODE_DISABLED;
                  status  = cic_pkg::ST_ACK;
               end
               cic_pkg::CHAR_ONE: begin
                  arg_ctl.clear = advance;
                  found_in  = 1'b0;
                  one_in    = 1'b1;
                  mode_in   = cic_pkg::MODE_MOVING;
                  period_in = fast_period_ff;
                  status    = cic_pkg::ST_ONE_STARTED;
               end
               default: begin
                  arg_ctl.take = advance;
                  if (arg_sts.run) begin
                     if (arg_sts.letter) begin
                        last_in = arg_sts.value - 8'd1;
                        status  = cic_pkg::ST_ACK;
                     end else begin
                        move_req  = 1'b1;
                        move_dest = arg_sts.value;
                     end
                  end
               end
            endcase
         end
         cic_pkg::CMD_IR: begin
            if (mode_ff == cic_pkg::MODE_MOVING) begin
               if (in_word_ff.ir_level) begin
                  // Nub leaving: finish a homing measurement or a slowed move.
                  if (homing_ff && edge_ff) begin
                     edge_in = 1'b0;
                     if (!counting_ff) begin
                        homing_in = 1'b0;
                        mode_in   = cic_pkg::MODE_DISABLED;
                        if (pend_ff) begin
                           pend_in = 1'b0;
                           if (pos_ff != dest_ff) begin
                              move_req = 1'b1;
                           end else begin
                              mode_in = cic_pkg::MODE_HOLDING;
                              status  = cic_pkg::ST_DONE_MOVE;
                           end
                        end else begin
                           status = cic_pkg::ST_HOMED;
                        end
                     end else begin
                        period_in = home_fast_ff;
                        status    = cic_pkg::ST_NOT_HOME;
                     end
                  end else if (found_ff) begin
                     mode_in = cic_pkg::MODE_HOLDING;
                     status  = one_ff ? cic_pkg::ST_ONE_DONE : cic_pkg::ST_DONE_MOVE;
                  end
               end else begin
                  // Nub entering: start measuring, or find or count a slot.
                  if (homing_ff) begin
                     edge_in     = 1'b1;
                     counting_in = 1'b1;
                     period_in   = home_slow_ff;
                     steps_in    = 16'd0;
                  end else if (one_ff) begin
                     period_in = slow_period_ff;
                     found_in  = 1'b1;
                     status    = cic_pkg::ST_FOUND;
                  end else begin
                     pos_in = pos_next;
                     if (pos_next == dest_ff) begin
                        period_in = slow_period_ff;
                        found_in  = 1'b1;
                        status    = cic_pkg::ST_FOUND;
                     end else begin
                        status = cic_pkg::ST_STEPPED;
                     end
                  end
               end
            end else if (mode_ff == cic_pkg::MODE_DISABLED && !in_word_ff.ir_level) begin
               pend_in = 1'b1;
               status  = cic_pkg::ST_BUMP;
            end
         end
         cic_pkg::CMD_TICK: begin
            if (counting_ff) begin
               steps_in = steps_inc;
               if (steps_inc == home_threshold_ff) begin
                  counting_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase

      // Start of a move to an index, shared by the serial and IR paths.
      if (move_req) begin
         dest_in  = move_dest;
         found_in = 1'b0;
         one_in   = 1'b0;
         if (pend_in) begin
            homing_in = 1'b1;
            pos_in    = 8'd0;
            mode_in   = cic_pkg::MODE_MOVING;
            period_in = home_fast_ff;
            status    = cic_pkg::ST_HOMING;
         end else if (move_dest > last_in) begin
            status = cic_pkg::ST_OUT_OF_RANGE;
         end else if (pos_in == move_dest) begin
            mode_in = cic_pkg::MODE_HOLDING;
            status  = cic_pkg::ST_DONE_MOVE;
         end else begin
            mode_in   = cic_pkg::MODE_MOVING;
            period_in = fast_period_ff;
            status    = cic_pkg::ST_MOVE_STARTED;
         end
      end

      out_word_in.motor_mode    = mode_in;
      out_word_in.step_period   = period_in;
      out_word_in.current_index = pos_in;
      out_word_in.target_index  = dest_in;
      out_word_in.status        = status;
   end

   // Input register, output register and controller state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= cic_pkg::MODE_DISABLED;
         period_ff    <= 8'd0;
         pos_ff       <= 8'd0;
         dest_ff      <= 8'd0;
         last_ff      <= cic_pkg::LAST_INDEX_RESET;
         one_ff       <= 1'b0;
         found_ff     <= 1'b0;
         homing_ff    <= 1'b0;
         pend_ff      <= 1'b0;
         edge_ff      <= 1'b0;
         counting_ff  <= 1'b0;
         steps_ff     <= 16'd0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            mode_ff      <= mode_in;
            period_ff    <= period_in;
            pos_ff       <= pos_in;
            dest_ff      <= dest_in;
            last_ff      <= last_in;
            one_ff       <= one_in;
            found_ff     <= found_in;
            homing_ff    <= homing_in;
            pend_ff      <= pend_in;
            edge_ff      <= edge_in;
            counting_ff  <= counting_in;
            steps_ff     <= steps_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (req_ready && req_valid) begin
         in_word_ff <= req_payload;
      end
      if (advance) begin
         out_word_ff <= out_word_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         home_threshold_ff <= cic_pkg::HOME_THRESHOLD_RESET;
         fast_period_ff    <= cic_pkg::FAST_MOVE_PERIOD_RESET;
         slow_period_ff    <= cic_pkg::SLOW_MOVE_PERIOD_RESET;
         home_fast_ff      <= cic_pkg::HOME_FAST_PERIOD_RESET;
         home_slow_ff      <= cic_pkg::HOME_SLOW_PERIOD_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            cic_pkg::CSR_HOME_THRESHOLD:   home_threshold_ff <= csr_data;
            cic_pkg::CSR_FAST_MOVE_PERIOD: fast_period_ff    <= csr_data[7:0];
            cic_pkg::CSR_SLOW_MOVE_PERIOD: slow_period_ff    <= csr_data[7:0];
            cic_pkg::CSR_HOME_FAST_PERIOD: home_fast_ff      <= csr_data[7:0];
            cic_pkg::CSR_HOME_SLOW_PERIOD: home_slow_ff      <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

`ifndef SYNTHESIS
   // A processed word always shows up as a result in the next cycle.
   a_result_after_advance: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("processed word did not produce a result");

   // A registered word that cannot advance is kept.
   a_input_kept: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("stalled request word was dropped");

   // The nub edge flag is only set during homing.
   a_edge_needs_homing: assert property (@(posedge clock) disable iff (reset)
      edge_ff |-> homing_ff)
      else $error("edge flag set outside homing");

   // The motor mode never takes the spare code.
   a_mode_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.motor_mode != cic_pkg::MODE_SPARE))
      else $error("illegal motor mode in result");
`endif

endmodule

FILE: test/carousel_indexer_controller_core_test.sv
// Self-checking testbench for carousel_indexer_controller_core: random and directed events,
// an in-line behavioral predictor of the controller, and a word-by-word result check.
// Depends on cic_pkg and the RTL of the controller core.
`timescale 1ns / 1ps

module carousel_indexer_controller_core_test;

   localparam int unsigned DIGITS = cic_pkg::ARG_DIGITS_DEFAULT;
   localparam int unsigned PHASES = 6;
   localparam int unsigned PHASE_WORDS = 290;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam longint unsigned RUN_LIMIT_NS = 64'd4_000_000;

   // Clock, reset and the block's ports; the ones driven here are known from time zero.
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   cic_pkg::req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   cic_pkg::rsp_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [cic_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [cic_pkg::CSR_DATA_W-1:0] csr_data = '0;

   // Event words waiting to be sent and result words still owed by the block.
   cic_pkg::req_type event_queue[$];
   cic_pkg::rsp_type pending_results[$];
   bit idle_on = 1'b1;
   int send_gap = 0;
   int stall_left = 0;
   int mismatch_count = 0;
   int result_count = 0;
   int phase_words = 0;

   // Predictor copy of the configuration registers.
   logic [15:0] cfg_home_threshold = cic_pkg::HOME_THRESHOLD_RESET;
   logic [7:0] cfg_fast = cic_pkg::FAST_MOVE_PERIOD_RESET;
   logic [7:0] cfg_slow = cic_pkg::SLOW_MOVE_PERIOD_RESET;
   logic [7:0] cfg_home_fast = cic_pkg::HOME_FAST_PERIOD_RESET;
   logic [7:0] cfg_home_slow = cic_pkg::HOME_SLOW_PERIOD_RESET;

   // Predictor copy of the controller state.
   cic_pkg::mode_type ctl_mode = cic_pkg::MODE_DISABLED;
   logic [7:0] ctl_period = '0;
   logic [7:0] ctl_index = '0;
   logic [7:0] ctl_target = '0;
   logic [7:0] ctl_last_index = cic_pkg::LAST_INDEX_RESET;
   logic [15:0] step_ticks = '0;
   bit one_slot = 1'b0;
   bit slot_found = 1'b0;
   bit homing = 1'b0;
   bit home_needed = 1'b0;
   bit nub_seen = 1'b0;
   bit nub_counting = 1'b0;
   bit arg_is_count = 1'b0;
   logic [7:0] arg_digits[DIGITS] = '{default: '0};
   int arg_pos = 0;

   carousel_indexer_controller_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Search for the home nub: the index restarts at zero.
   function automatic cic_pkg::status_type begin_homing();
      homing = 1'b1;
      ctl_index = '0;
      ctl_mode = cic_pkg::MODE_MOVING;
      ctl_period = cfg_home_fast;
      return cic_pkg::ST_HOMING;
   endfunction

   // Travel to an index, unless a home search has to come first.
   function automatic cic_pkg::status_type begin_travel(logic [7:0] dest);
      ctl_target = dest;
      slot_found = 1'b0;
      one_slot = 1'b0;
      if (home_needed)
         return begin_homing();
      if (ctl_target > ctl_last_index)
         return cic_pkg::ST_OUT_OF_RANGE;
      if (ctl_index == ctl_target) begin
         ctl_mode = cic_pkg::MODE_HOLDING;
         return cic_pkg::ST_DONE_MOVE;
      end
      ctl_mode = cic_pkg::MODE_MOVING;
      ctl_period = cfg_fast;
      return cic_pkg::ST_MOVE_STARTED;
   endfunction

   // Serial byte: single-letter commands, or argument collection for move and count.
   function automatic cic_pkg::status_type take_serial_byte(logic [7:0] b);
      logic [7:0] value;
      case (b)
         cic_pkg::CHAR_MOVE: begin
            arg_is_count = 1'b0;
            arg_pos = 1;
            return cic_pkg::ST_NONE;
         end
         cic_pkg::CHAR_COUNT: begin
            arg_is_count = 1'b1;
            arg_pos = 1;
            return cic_pkg::ST_NONE;
         end
         cic_pkg::CHAR_HOME: begin
            arg_pos = 0;
            return begin_homing();
         end
         cic_pkg::CHAR_ENABLE: begin
            arg_pos = 0;
            ctl_mode = cic_pkg::MODE_HOLDING;
            return cic_pkg::ST_ACK;
         end
         cic_pkg::CHAR_DISABLE: begin
            arg_pos = 0;
            ctl_mode = cic_pkg::MODE_DISABLED;
            return cic_pkg::ST_ACK;
         end
         cic_pkg::CHAR_ONE: begin
            arg_pos = 0;
            slot_found = 1'b0;
            one_slot = 1'b1;
            ctl_mode = cic_pkg::MODE_MOVING;
            ctl_period = cfg_fast;
            return cic_pkg::ST_ONE_STARTED;
         end
         default: ;
      endcase
      if (arg_pos > 0 && arg_pos <= DIGITS) begin
         arg_digits[arg_pos - 1] = b;
         arg_pos++;
         return cic_pkg::ST_NONE;
      end
      if (arg_pos == DIGITS + 1) begin
         // The terminating byte itself is dropped; the value wraps modulo 256.
         arg_pos = 0;
         value = '0;
         for (int k = 0; k < DIGITS; k++)
            value = value * 8'd10 + (arg_digits[k] - cic_pkg::CHAR_ZERO);
         if (!arg_is_count)
            return begin_travel(value);
         ctl_last_index = value - 8'd1;
         return cic_pkg::ST_ACK;
      end
      return cic_pkg::ST_NONE;
   endfunction

   // IR level change: nub edges while moving, or a bump while disabled.
   function automatic cic_pkg::status_type take_ir_change(logic level);
      if (ctl_mode == cic_pkg::MODE_MOVING) begin
         if (level) begin
            if (homing && nub_seen) begin
               nub_seen = 1'b0;
               if (!nub_counting) begin
                  homing = 1'b0;
                  ctl_mode = cic_pkg::MODE_DISABLED;
                  if (home_needed) begin
                     home_needed = 1'b0;
                     if (ctl_index != ctl_target)
                        return begin_travel(ctl_target);
                     ctl_mode = cic_pkg::MODE_HOLDING;
                     return cic_pkg::ST_DONE_MOVE;
                  end
                  return cic_pkg::ST_HOMED;
               end
               // Nub too short: go back to the fast search.
               ctl_period = cfg_home_fast;
               return cic_pkg::ST_NOT_HOME;
            end
            if (slot_found) begin
               ctl_mode = cic_pkg::MODE_HOLDING;
               return one_slot ? cic_pkg::ST_ONE_DONE : cic_pkg::ST_DONE_MOVE;
            end
            return cic_pkg::ST_NONE;
         end
         if (homing) begin
            nub_seen = 1'b1;
            nub_counting = 1'b1;
            ctl_period = cfg_home_slow;
            step_ticks = '0;
            return cic_pkg::ST_NONE;
         end
         if (one_slot) begin
            ctl_period = cfg_slow;
            slot_found = 1'b1;
            return cic_pkg::ST_FOUND;
         end
         ctl_index = (ctl_index == ctl_last_index) ? 8'd0 : ctl_index + 8'd1;
         if (ctl_index == ctl_target) begin
            ctl_period = cfg_slow;
            slot_found = 1'b1;
            return cic_pkg::ST_FOUND;
         end
         return cic_pkg::ST_STEPPED;
      end
      if (ctl_mode == cic_pkg::MODE_DISABLED && !level) begin
         home_needed = 1'b1;
         return cic_pkg::ST_BUMP;
      end
      return cic_pkg::ST_NONE;
   endfunction

   // Result word that the controller gives for one event word.
   function automatic cic_pkg::rsp_type controller_result(cic_pkg::req_type ev);
      cic_pkg::rsp_type word;
      cic_pkg::status_type st;
      st = cic_pkg::ST_NONE;
      case (ev.cmd)
         cic_pkg::CMD_SERIAL: st = take_serial_byte(ev.rx_byte);
         cic_pkg::CMD_IR: st = take_ir_change(ev.ir_level);
         cic_pkg::CMD_TICK: begin
            if (nub_counting) begin
               step_ticks = step_ticks + 16'd1;
               if (step_ticks == cfg_home_threshold)
                  nub_counting = 1'b0;
            end
         end
         default: ;
      endcase
      word.motor_mode = ctl_mode;
      word.step_period = ctl_period;
      word.current_index = ctl_index;
      word.target_index = ctl_target;
      word.status = st;
      return word;
   endfunction

   // Event driver: predicts on acceptance, then presents the next word or idles.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_payload <= '0;
      end else begin
         if (req_valid && req_ready)
            pending_results.push_back(controller_result(req_payload));
         if (!req_valid || req_ready) begin
            if (idle_on && send_gap > 0) begin
               send_gap = send_gap - 1;
               req_valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
               send_gap = $urandom_range(0, 16);
               req_valid <= 1'b0;
            end else if (event_queue.size() != 0) begin
               req_valid <= 1'b1;
               req_payload <= event_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Report a field that differs from its prediction; only the first ten are shown.
   task automatic flag_mismatch(input string field, input logic [7:0] want,
                                input logic [7:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("result word %0d: %s expected %0d, got %0d", result_count, field, want,
                  got);
   endtask

   // Result monitor: checks each accepted word against the oldest prediction.
   always @(posedge clock) begin : result_monitor
      cic_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result word %0d arrived with none outstanding: %h", result_count,
                           rsp_payload);
            end else begin
               want = pending_results.pop_front();
               if (rsp_payload.motor_mode !== want.motor_mode)
                  flag_mismatch("motor_mode", 8'(want.motor_mode),
                                8'(rsp_payload.motor_mode));
               if (rsp_payload.step_period !== want.step_period)
                  flag_mismatch("step_period", want.step_period, rsp_payload.step_period);
               if (rsp_payload.current_index !== want.current_index)
                  flag_mismatch("current_index", want.current_index,
                                rsp_payload.current_index);
               if (rsp_payload.target_index !== want.target_index)
                  flag_mismatch("target_index", want.target_index, rsp_payload.target_index);
               if (rsp_payload.status !== want.status)
                  flag_mismatch("status", 8'(want.status), 8'(rsp_payload.status));
            end
            result_count++;
         end
         if (idle_on && stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 16);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic push_word(input logic [1:0] kind, input logic [7:0] b, input logic level);
      event_queue.push_back('{cmd: kind, rx_byte: b, ir_level: level});
      phase_words++;
   endtask

   // Any byte that is not a command letter.
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do
         b = 8'($urandom);
      while (b == cic_pkg::CHAR_MOVE || b == cic_pkg::CHAR_COUNT ||
             b == cic_pkg::CHAR_HOME || b == cic_pkg::CHAR_ENABLE ||
             b == cic_pkg::CHAR_DISABLE || b == cic_pkg::CHAR_ONE);
      return b;
   endfunction

   // Letter, three digits (or garbage in their place) and a terminating byte.
   task automatic push_argument(input logic [7:0] letter, input int value, input bit garble);
      push_word(cic_pkg::CMD_SERIAL, letter, 1'($urandom));
      if (garble) begin
         repeat (DIGITS) push_word(cic_pkg::CMD_SERIAL, plain_byte(), 1'($urandom));
      end else begin
         push_word(cic_pkg::CMD_SERIAL, cic_pkg::CHAR_ZERO + 8'(value / 100 % 10),
                   1'($urandom));
         push_word(cic_pkg::CMD_SERIAL, cic_pkg::CHAR_ZERO + 8'(value / 10 % 10),
                   1'($urandom));
         push_word(cic_pkg::CMD_SERIAL, cic_pkg::CHAR_ZERO + 8'(value % 10), 1'($urandom));
      end
      push_word(cic_pkg::CMD_SERIAL, plain_byte(), 1'($urandom));
   endtask

   // Nub passes: entering edge, up to 40 ticks or twice a smaller threshold, leaving edge.
   task automatic push_nub_passes();
      int ticks;
      repeat ($urandom_range(1, 3)) begin
         push_word(cic_pkg::CMD_IR, 8'($urandom), 1'b0);
         if (cfg_home_threshold <= 16'd40)
            ticks = $urandom_range(0, 2 * cfg_home_threshold);
         else
            ticks = $urandom_range(0, 40);
         repeat (ticks) push_word(cic_pkg::CMD_TICK, 8'($urandom), 1'($urandom));
         push_word(cic_pkg::CMD_IR, 8'($urandom), 1'b1);
      end
   endtask

   // One well-formed sequence with random content, or a broken one, or noise.
   task automatic push_random_sequence();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         push_word(cic_pkg::CMD_SERIAL, cic_pkg::CHAR_HOME, 1'($urandom));
         push_nub_passes();
      end else if (pick < 25) begin
         // Bump while disabled, then a move that has to home first.
         push_word(cic_pkg::CMD_SERIAL, cic_pkg::CHAR_DISABLE, 1'($urandom));
         push_word(cic_pkg::CMD_IR, 8'($urandom), 1'b0);
         push_argument(cic_pkg::CHAR_MOVE, $urandom_range(0, 12), 1'b0);
         push_nub_passes();
         repeat ($urandom_range(0, 10)) push_word(cic_pkg::CMD_IR, 8'($urandom), 1'b0);
         push_word(cic_pkg::CMD_IR, 8'($urandom), 1'b1);
      end else if (pick < 45) begin
         push_argument(cic_pkg::CHAR_MOVE,
                       ($urandom_range(0, 9) == 0) ? $urandom_range(0, 999) :
                       $urandom_range(0, 16), $urandom_range(0, 11) == 0);
         repeat ($urandom_range(0, 16)) begin
            push_word(cic_pkg::CMD_IR, 8'($urandom), $urandom_range(0, 4) == 0);
            if ($urandom_range(0, 5) == 0)
               push_word(cic_pkg::CMD_TICK, 8'($urandom), 1'($urandom));
         end
         push_word(cic_pkg::CMD_IR, 8'($urandom), 1'b1);
      end else if (pick < 53) begin
         push_argument(cic_pkg::CHAR_COUNT,
                       ($urandom_range(0, 7) == 0) ? $urandom_range(0, 999) :
                       $urandom_range(1, 16), $urandom_range(0, 11) == 0);
      end else if (pick < 63) begin
         push_word(cic_pkg::CMD_SERIAL, cic_pkg::CHAR_ONE, 1'($urandom));
         repeat ($urandom_range(1, 2)) push_word(cic_pkg::CMD_IR, 8'($urandom), 1'b0);
         push_word(cic_pkg::CMD_IR, 8'($urandom), 1'b1);
      end else if (pick < 72) begin
         push_word(cic_pkg::CMD_SERIAL,
                   $urandom_range(0, 1) ? cic_pkg::CHAR_ENABLE : cic_pkg::CHAR_DISABLE,
                   1'($urandom));
         push_word(cic_pkg::CMD_IR, 8'($urandom), 1'($urandom));
      end else if (pick < 82) begin
         // Argument cut short by another command, or left open around an IR event.
         push_word(cic_pkg::CMD_SERIAL,
                   $urandom_range(0, 1) ? cic_pkg::CHAR_MOVE : cic_pkg::CHAR_COUNT,
                   1'($urandom));
         repeat ($urandom_range(0, DIGITS - 1))
            push_word(cic_pkg::CMD_SERIAL, cic_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)),
                      1'($urandom));
         case ($urandom_range(0, 3))
            0: push_word(cic_pkg::CMD_SERIAL, cic_pkg::CHAR_ENABLE, 1'($urandom));
            1: push_word(cic_pkg::CMD_SERIAL, cic_pkg::CHAR_DISABLE, 1'($urandom));
            2: push_word(cic_pkg::CMD_SERIAL, cic_pkg::CHAR_MOVE, 1'($urandom));
            default: push_word(cic_pkg::CMD_IR, 8'($urandom), 1'($urandom));
         endcase
      end else begin
         repeat ($urandom_range(1, 4))
            push_word(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
      end
   endtask

   // Hold the sender until every predicted word has come back, then let the block settle.
   task automatic wait_idle();
      while (event_queue.size() != 0 || req_valid || pending_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write; valid stays up so that a following write is back to back.
   task automatic write_register(input logic [cic_pkg::CSR_INDEX_W-1:0] idx,
                                 input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (idx)
         cic_pkg::CSR_HOME_THRESHOLD: cfg_home_threshold = value;
         cic_pkg::CSR_FAST_MOVE_PERIOD: cfg_fast = value[7:0];
         cic_pkg::CSR_SLOW_MOVE_PERIOD: cfg_slow = value[7:0];
         cic_pkg::CSR_HOME_FAST_PERIOD: cfg_home_fast = value[7:0];
         cic_pkg::CSR_HOME_SLOW_PERIOD: cfg_home_slow = value[7:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [15:0] threshold, input logic [7:0] fast,
                            input logic [7:0] slow, input logic [7:0] home_fast,
                            input logic [7:0] home_slow);
      write_register(cic_pkg::CSR_HOME_THRESHOLD, threshold);
      write_register(cic_pkg::CSR_FAST_MOVE_PERIOD, 16'(fast));
      write_register(cic_pkg::CSR_SLOW_MOVE_PERIOD, 16'(slow));
      write_register(cic_pkg::CSR_HOME_FAST_PERIOD, 16'(home_fast));
      write_register(cic_pkg::CSR_HOME_SLOW_PERIOD, 16'(home_slow));
      csr_valid <= 1'b0;
   endtask

   // Stimulus: reset, directed events, then phases of random sequences under new settings.
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            1: configure(16'd5, 8'd0, 8'd255, 8'd1, 8'd254);
            2: configure(16'd1, 8'd255, 8'd0, 8'd255, 8'd0);
            3: configure(16'd65535, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            4: configure(16'($urandom_range(2, 30)), 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom));
            5: configure(16'd12, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            default: ;
         endcase
         // The last two phases run without any idling.
         idle_on = (phase < PHASES - 2);
         phase_words = 0;
         if (phase == 0) begin
            push_word(cic_pkg::CMD_TICK, 8'h00, 1'b0);
            push_word(cic_pkg::CMD_UNUSED, 8'hFF, 1'b1);
            push_word(cic_pkg::CMD_SERIAL, 8'hFF, 1'b1);
            push_word(cic_pkg::CMD_IR, 8'h00, 1'b1);
            push_word(cic_pkg::CMD_SERIAL, cic_pkg::CHAR_ENABLE, 1'b0);
            push_word(cic_pkg::CMD_SERIAL, cic_pkg::CHAR_ONE, 1'b0);
            push_word(cic_pkg::CMD_IR, 8'h00, 1'b0);
            push_word(cic_pkg::CMD_IR, 8'h00, 1'b1);
            push_argument(cic_pkg::CHAR_COUNT, 10, 1'b0);
            push_argument(cic_pkg::CHAR_MOVE, 3, 1'b0);
            repeat (3) push_word(cic_pkg::CMD_IR, 8'h00, 1'b0);
            push_word(cic_pkg::CMD_IR, 8'h00, 1'b1);
            push_word(cic_pkg::CMD_SERIAL, cic_pkg::CHAR_DISABLE, 1'b0);
            push_word(cic_pkg::CMD_IR, 8'h00, 1'b0);
            push_argument(cic_pkg::CHAR_MOVE, 999, 1'b0);
         end
         while (phase_words < PHASE_WORDS)
            push_random_sequence();
         wait_idle();
      end
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // Run limit, far above the slowest correct run.
   initial begin
      #(RUN_LIMIT_NS);
      $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/cic_pkg.sv
rtl/cic_args.sv
rtl/carousel_indexer_controller_core.sv
test/carousel_indexer_controller_core_test.sv
